/* rtl/core/zdp_pkg.sv */
// Package: shared constants, request/response types and codes for the distance profile core.
`timescale 1ns / 1ps
`default_nettype none

package zdp_pkg;

  localparam int MaxWindow  = 256;
  localparam int AddrW      = $clog2(MaxWindow);
  localparam int WinW       = AddrW + 1;
  localparam int MaxSamples = 65536;
  localparam int SeenW      = $clog2(MaxSamples) + 1;

  localparam int SmpW    = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int FracW   = 16;

  localparam int AccW  = 2 * SmpW + AddrW;
  localparam int NumW  = AccW + 1;
  localparam int MagW  = AccW;
  localparam int DvdW  = MagW + FracW;
  localparam int DvsW  = 2 * SmpW;
  localparam int MulAW = 2 * SmpW + 1;
  localparam int MulBW = SmpW + 1;
  localparam int ProdW = MulAW + MulBW;

  localparam int DistW  = 27;
  localparam int DotW   = 39;
  localparam int StartW = 16;
  localparam int WlW    = WinW + FracW;

  localparam logic [DistW-1:0] DistMax = DistW'(67108864);
  localparam logic [WinW-1:0]  WinMin  = WinW'(2);
  localparam logic [WinW-1:0]  WinMax  = WinW'(MaxWindow);

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIN_LEN = 2'd0,
    CFG_QMEAN   = 2'd1,
    CFG_QDEV    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_MAC,
    MUL_MEAN,
    MUL_SCALE,
    MUL_DEV
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MEAN,
    ST_SCALE,
    ST_DEV,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [SmpW-1:0] sample;
    logic signed [SmpW-1:0] win_mean;
    logic [SmpW-1:0]        win_deviation;
  } zdp_req_t;

  typedef struct packed {
    logic [DistW-1:0]       distance;
    logic signed [DotW-1:0] dot_product;
    logic [StartW-1:0]      window_start;
    logic                   zero_deviation;
  } zdp_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/zdp_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module zdp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/zdp_mult.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module zdp_mult (
  input  wire logic                          clk_i,
  input  wire logic signed [zdp_pkg::MulAW-1:0] a_i,
  input  wire logic signed [zdp_pkg::MulBW-1:0] b_i,
  output logic      signed [zdp_pkg::ProdW-1:0] prod_o
);
  import zdp_pkg::*;

  logic signed [ProdW-1:0] prod_d;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule

`default_nettype wire

/* rtl/core/zdp_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module zdp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [zdp_pkg::DvdW-1:0]   dividend_i,
  input  wire logic [zdp_pkg::DvsW-1:0]   divisor_i,
  output logic                            done_o,
  output logic      [zdp_pkg::DvdW-1:0]   quotient_o
);
  import zdp_pkg::*;

  localparam int CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] LastStep = CntW'(DvdW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/zscore_distance_profile_core.sv */
// Top level: z-normalized distance profile core with sequencer, query and history stores.
`timescale 1ns / 1ps
`default_nettype none

// Query requests (op 0), clear requests (op 2), unused codes, a full stream and data
// requests that do not yet complete a window are handled in the idle state. A data
// request that completes a window of w samples runs through one shared multiplier and
// a serial divider: multiply-accumulate over the query and history RAMs, pipeline
// drain, the mean and deviation products, the divider (skipped when the deviation
// product is zero) and the load of the result, held back while an earlier result
// still waits. The core takes no request while busy; a finished result sits in an
// output register so the next request can be taken while it waits.
module zscore_distance_profile_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire zdp_pkg::zdp_req_t              in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output zdp_pkg::zdp_rsp_t                   out_rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [zdp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [zdp_pkg::CfgW-1:0]       cfg_wdata_i
);
  import zdp_pkg::*;

  state_e state_q, state_d;

  logic [WinW-1:0]        wl_q;
  logic signed [SmpW-1:0] qmu_q;
  logic [SmpW-1:0]        qsd_q;

  logic [SeenW-1:0]       seen_q, seen_d;
  logic [WinW-1:0]        qp_q, qp_d;
  logic [StartW-1:0]      start_q, start_d;
  logic signed [SmpW-1:0] mu_q, mu_d;
  logic [SmpW-1:0]        sd_q, sd_d;
  logic [WinW-1:0]        idx_q, idx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic                   prd_vld_q;
  logic                   qv_rd_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [NumW-1:0] num_q, num_d;
  logic                   zero_q, zero_d;
  logic [MaxWindow-1:0]   qvld_q;
  logic                   out_vld_q, out_vld_d;
  zdp_rsp_t               out_q, out_d;

  logic [WinW-1:0]        w_eff;
  logic                   accept;
  logic                   q_we;
  logic [AddrW-1:0]       q_waddr;
  logic                   h_we;
  logic [AddrW-1:0]       h_raddr;
  logic [SmpW-1:0]        q_rdata;
  logic [SmpW-1:0]        h_rdata;
  logic [SmpW-1:0]        q_val;
  mul_sel_e               mul_sel;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic                   div_start;
  logic                   div_done;
  logic [DvdW-1:0]        quo;
  logic [NumW-1:0]        num_abs;
  logic [WinW-1:0]        qp_wr;
  logic [WinW-1:0]        qp_inc;
  logic [SeenW-1:0]       seen_inc;
  logic [DistW-1:0]       q_sat;
  logic [WlW-1:0]         wl_fix;
  logic [DistW:0]         dist_sum;
  logic [WlW-1:0]         dist_diff;
  logic [DistW-1:0]       dist_val;
  logic signed [DotW-1:0] dot_sat;

  assign w_eff = (wl_q < WinMin) ? WinMin : ((wl_q > WinMax) ? WinMax : wl_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // query pointer wraps before the write when the window shrank
  assign qp_wr  = (qp_q >= w_eff) ? '0 : qp_q;
  assign qp_inc = qp_wr + 1'b1;
  assign q_we    = accept && (in_req_i.op == OP_QUERY);
  assign q_waddr = qp_wr[AddrW-1:0];
  assign h_we    = accept && (in_req_i.op == OP_DATA) && !seen_q[SeenW-1];
  assign h_raddr = start_q[AddrW-1:0] + idx_q[AddrW-1:0];
  assign seen_inc = seen_q + 1'b1;

  zdp_ram #(
    .Width(SmpW),
    .Depth(MaxWindow)
  ) u_query_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(in_req_i.sample),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(q_rdata)
  );

  zdp_ram #(
    .Width(SmpW),
    .Depth(MaxWindow)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(seen_q[AddrW-1:0]),
    .wdata_i(in_req_i.sample),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  // never-loaded query entries read as zero
  assign q_val = qv_rd_q ? q_rdata : '0;

  always_comb begin
    case (mul_sel)
      MUL_MAC: begin
        mul_a = {{(MulAW-SmpW){q_val[SmpW-1]}}, q_val};
        mul_b = {h_rdata[SmpW-1], h_rdata};
      end
      MUL_MEAN: begin
        mul_a = {{(MulAW-SmpW){mu_q[SmpW-1]}}, mu_q};
        mul_b = {qmu_q[SmpW-1], qmu_q};
      end
      MUL_SCALE: begin
        mul_a = prod[MulAW-1:0];
        mul_b = {{(MulBW-WinW){1'b0}}, w_eff};
      end
      MUL_DEV: begin
        mul_a = {{(MulAW-SmpW){1'b0}}, sd_q};
        mul_b = {1'b0, qsd_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  zdp_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign num_abs = num_q[NumW-1] ? NumW'(-num_q) : num_q;

  zdp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({num_abs[MagW-1:0], {FracW{1'b0}}}),
    .divisor_i (prod[DvsW-1:0]),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  // distance = 2*(w - ratio), clamped to 0..DistMax
  assign q_sat     = (|quo[DvdW-1:DistW-1]) ? DistMax : {1'b0, quo[DistW-2:0]};
  assign wl_fix    = {w_eff, {FracW{1'b0}}};
  assign dist_sum  = {{(DistW+1-WlW){1'b0}}, wl_fix} + {1'b0, q_sat};
  assign dist_diff = wl_fix - q_sat[WlW-1:0];

  always_comb begin
    if (zero_q) begin
      dist_val = DistMax;
    end else if (num_q[NumW-1]) begin
      dist_val = (dist_sum >= (DistW+1)'(1 << WlW)) ? DistMax
                                                      : {1'b0, dist_sum[WlW-1:0], 1'b0};
    end else begin
      dist_val = ({{(DistW-WlW){1'b0}}, wl_fix} <= q_sat) ? '0 : {1'b0, dist_diff, 1'b0};
    end
  end

  always_comb begin
    if (acc_q[AccW-1] != acc_q[AccW-2]) begin
      dot_sat = acc_q[AccW-1] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
    end else begin
      dot_sat = acc_q[DotW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    qp_d      = qp_q;
    start_d   = start_q;
    mu_d      = mu_q;
    sd_d      = sd_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    acc_d     = prd_vld_q ? acc_q + prod[AccW-1:0] : acc_q;
    num_d     = num_q;
    zero_d    = zero_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    mul_sel   = MUL_MAC;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_i.op)
            OP_QUERY: begin
              qp_d = (qp_inc >= w_eff) ? '0 : qp_inc;
            end
            OP_DATA: begin
              if (!seen_q[SeenW-1]) begin
                seen_d  = seen_inc;
                start_d = StartW'(seen_inc - {{(SeenW-WinW){1'b0}}, w_eff});
                mu_d    = in_req_i.win_mean;
                sd_d    = in_req_i.win_deviation;
                idx_d   = '0;
                acc_d   = '0;
                if (seen_inc >= {{(SeenW-WinW){1'b0}}, w_eff}) begin
                  state_d = ST_MAC;
                end
              end
            end
            OP_CLEAR: begin
              seen_d = '0;
              qp_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        rd_vld_d = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (idx_q == w_eff - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prd_vld_q) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        mul_sel = MUL_MEAN;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        mul_sel = MUL_SCALE;
        state_d = ST_DEV;
      end
      ST_DEV: begin
        mul_sel = MUL_DEV;
        num_d   = {acc_q[AccW-1], acc_q} - {prod[AccW-1], prod[AccW-1:0]};
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        zero_d = (prod[DvsW-1:0] == '0);
        if (prod[DvsW-1:0] == '0) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d            = 1'b1;
          out_d.distance       = dist_val;
          out_d.dot_product    = dot_sat;
          out_d.window_start   = start_q;
          out_d.zero_deviation = zero_q;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seen_q    <= '0;
      qp_q      <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      prd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      qvld_q    <= '0;
      wl_q      <= WinW'(8);
      qmu_q     <= '0;
      qsd_q     <= SmpW'(256);
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      qp_q      <= qp_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      prd_vld_q <= rd_vld_q;
      out_vld_q <= out_vld_d;
      if (q_we) begin
        qvld_q[q_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIN_LEN: wl_q  <= cfg_wdata_i[WinW-1:0];
          CFG_QMEAN:   qmu_q <= cfg_wdata_i;
          CFG_QDEV:    qsd_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    mu_q    <= mu_d;
    sd_q    <= sd_d;
    acc_q   <= acc_d;
    num_q   <= num_d;
    zero_q  <= zero_d;
    qv_rd_q <= qvld_q[idx_q[AddrW-1:0]];
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for zscore_distance_profile_core: directed and random requests scored against a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import zdp_pkg::*;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned SettleCycles = 400;
  localparam longint      DotHi        = 64'sd274877906943;
  localparam longint      DotLo        = -64'sd274877906944;

  typedef struct packed {
    zdp_req_t req;
    logic     has_typed;
    zdp_rsp_t typed;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  zdp_req_t           in_req    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  zdp_rsp_t           out_rsp;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  // predictor state
  logic signed [SmpW-1:0] query_mem [MaxWindow];
  logic signed [SmpW-1:0] hist_mem  [MaxWindow];
  int unsigned            qry_ptr;
  int unsigned            seen_cnt;
  logic [WinW-1:0]        win_len;
  logic signed [SmpW-1:0] qry_mean;
  logic [SmpW-1:0]        qry_dev;

  zdp_rsp_t    dist_q [$];
  int unsigned err_cnt    = 0;
  int unsigned idle_cnt   = 0;
  int unsigned stall_left = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;

  zscore_distance_profile_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_win();
    int unsigned w;
    w = win_len;
    if (w < 2) w = 2;
    if (w > MaxWindow) w = MaxWindow;
    return w;
  endfunction

  function automatic zdp_req_t make_req(logic [1:0] op, logic [SmpW-1:0] smp,
                                        logic [SmpW-1:0] mean, logic [SmpW-1:0] dev);
    zdp_req_t r;
    r.op            = op;
    r.sample        = smp;
    r.win_mean      = mean;
    r.win_deviation = dev;
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] op, logic [SmpW-1:0] smp,
                                    logic [SmpW-1:0] mean, logic [SmpW-1:0] dev,
                                    logic has_typed, zdp_rsp_t typed);
    stim_row_t s;
    s.req       = make_req(op, smp, mean, dev);
    s.has_typed = has_typed;
    s.typed     = typed;
    return s;
  endfunction

  function automatic logic [SmpW-1:0] rand_sample(int unsigned sh);
    logic signed [SmpW-1:0] v;
    v = SmpW'($urandom);
    return v >>> sh;
  endfunction

  function automatic logic [SmpW-1:0] rand_dev();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return SmpW'($urandom_range(1, 255));
      default: return SmpW'($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  task automatic predict_profile(input zdp_req_t r, output bit got, output zdp_rsp_t rsp);
    int unsigned       w, start, i;
    longint            dot_sum, num, ratio, dist_v, dot;
    longint unsigned   den, mag, quo;
    w   = eff_win();
    got = 1'b0;
    rsp = '0;
    case (r.op)
      OP_QUERY: begin
        if (qry_ptr >= w) qry_ptr = 0;
        query_mem[qry_ptr] = r.sample;
        qry_ptr = (qry_ptr + 1 >= w) ? 0 : qry_ptr + 1;
      end
      OP_CLEAR: begin
        seen_cnt = 0;
        qry_ptr  = 0;
        for (i = 0; i < MaxWindow; i++) hist_mem[i] = '0;
      end
      OP_DATA: begin
        if (seen_cnt < MaxSamples) begin
          hist_mem[seen_cnt % MaxWindow] = r.sample;
          seen_cnt++;
          if (seen_cnt >= w) begin
            start   = seen_cnt - w;
            dot_sum = 0;
            for (i = 0; i < w; i++)
              dot_sum += longint'(query_mem[i]) * longint'(hist_mem[(start + i) % MaxWindow]);
            num = dot_sum - longint'(w) * longint'($signed(r.win_mean)) * longint'(qry_mean);
            den = longint'(r.win_deviation) * longint'(qry_dev);
            if (den == 0) begin
              dist_v = longint'(DistMax);
            end else begin
              mag    = (num < 0) ? -num : num;
              quo    = (mag << 16) / den;
              ratio  = (num < 0) ? -longint'(quo) : longint'(quo);
              dist_v = 2 * ((longint'(w) << 16) - ratio);
              if (dist_v < 0) dist_v = 0;
              if (dist_v > longint'(DistMax)) dist_v = longint'(DistMax);
            end
            dot = dot_sum;
            if (dot > DotHi) dot = DotHi;
            if (dot < DotLo) dot = DotLo;
            rsp.distance       = dist_v[DistW-1:0];
            rsp.dot_product    = dot[DotW-1:0];
            rsp.window_start   = start[StartW-1:0];
            rsp.zero_deviation = (den == 0);
            got = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input zdp_req_t r, input bit has_typed, input zdp_rsp_t typed);
    int unsigned gap;
    bit          got;
    zdp_rsp_t    rsp;
    gap = tx_idle_en ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    predict_profile(r, got, rsp);
    if (got) dist_q.push_back(has_typed ? typed : rsp);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WIN_LEN: win_len  = data[WinW-1:0];
      CFG_QMEAN:   qry_mean = data;
      CFG_QDEV:    qry_dev  = data;
      default: ;
    endcase
  endtask

  // result side: random stalls and field-by-field check
  always @(posedge clk or negedge rst_n) begin : rx_side
    zdp_rsp_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (out_ready && out_valid) begin
      if (dist_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_rsp);
      end else begin
        want = dist_q.pop_front();
        if (out_rsp.distance !== want.distance)
          note_mismatch("distance", want.distance, out_rsp.distance);
        if (out_rsp.dot_product !== want.dot_product)
          note_mismatch("dot_product", want.dot_product, out_rsp.dot_product);
        if (out_rsp.window_start !== want.window_start)
          note_mismatch("window_start", want.window_start, out_rsp.window_start);
        if (out_rsp.zero_deviation !== want.zero_deviation)
          note_mismatch("zero_deviation", want.zero_deviation, out_rsp.zero_deviation);
      end
      stall_left = rx_idle_en ? $urandom_range(0, 16) : 0;
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin : stimulus
    stim_row_t       stim_rows [$];
    int unsigned     ph, rand_items, w_eff, n_q, n_d, sh, k, i, pick;
    logic [WinW-1:0] wl;
    logic [CfgW-1:0] qm, qd;
    logic [1:0]      op;
    bit              do_clear, all_min;
    zdp_req_t        r;

    for (i = 0; i < MaxWindow; i++) begin
      query_mem[i] = '0;
      hist_mem[i]  = '0;
    end
    qry_ptr    = 0;
    seen_cnt   = 0;
    win_len    = WinW'(8);
    qry_mean   = '0;
    qry_dev    = SmpW'(256);
    rand_items = 0;

    // reset state: zero query, so the first full window gives distance 2*w
    stim_rows.push_back(row(OP_DATA, 16'h7fff, 16'h0000, 16'h0100, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h8000, 16'h7fff, 16'hffff, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h0000, 16'h8000, 16'h0001, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'hffff, 16'h0001, 16'h8000, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h0001, 16'hffff, 16'h7fff, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h5555, 16'haaaa, 16'h5555, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h0001, 16'h7fff, 16'hffff, 1'b1,
                            zdp_rsp_t'{distance: 27'd1048576, dot_product: '0,
                                       window_start: 16'd0, zero_deviation: 1'b0}));
    stim_rows.push_back(row(OP_DATA, 16'h0000, 16'h8000, 16'h0000, 1'b1,
                            zdp_rsp_t'{distance: DistMax, dot_product: '0,
                                       window_start: 16'd1, zero_deviation: 1'b1}));
    stim_rows.push_back(row(OpUnused, 16'h1234, 16'h5678, 16'h9abc, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h7fff, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h7fff, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h0001, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'hffff, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h5555, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'haaaa, 16'h0000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h8000, 16'h7fff, 16'hffff, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h7fff, 16'h8000, 16'h0001, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h8000, 16'h8000, 16'h0000, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h0000, 16'h0000, 16'h0100, 1'b0, '0));
    stim_rows.push_back(row(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 1'b0, '0));
    stim_rows.push_back(row(OP_DATA, 16'h7fff, 16'h0000, 16'h0100, 1'b0, '0));
    stim_rows.push_back(row(OP_QUERY, 16'h1234, 16'h0000, 16'h0000, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_en = ($urandom_range(0, 1) != 0);
    rx_idle_en = ($urandom_range(0, 1) != 0);
    foreach (stim_rows[k])
      send_req(stim_rows[k].req, stim_rows[k].has_typed, stim_rows[k].typed);

    for (ph = 0; ph < 5 || rand_items < 700; ph++) begin
      wl       = ($urandom_range(0, 9) == 0) ? WinW'($urandom_range(2, 511))
                                             : WinW'($urandom_range(2, 24));
      qm       = CfgW'($urandom);
      qd       = rand_dev();
      do_clear = ($urandom_range(0, 2) != 0);
      all_min  = 1'b0;
      sh       = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      case (ph)
        0: begin
          wl = WinW'(2);
          qm = 16'h8000;
          qd = 16'h0001;
        end
        1: begin
          // all-negative query and data over a clamped longest window:
          // dot product beyond its range
          wl       = WinW'(511);
          qm       = 16'h7fff;
          qd       = 16'hffff;
          all_min  = 1'b1;
          do_clear = 1'b1;
        end
        2: begin
          // query pointer left above the new window length
          wl       = WinW'(0);
          qd       = '0;
          do_clear = 1'b0;
        end
        4: wl = WinW'(1);
        default: ;
      endcase

      wait_drained();
      cfg_write(CFG_WIN_LEN, {7'($urandom), wl});
      cfg_write(CFG_QMEAN, qm);
      cfg_write(CFG_QDEV, qd);
      cfg_we <= 1'b0;
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      w_eff      = eff_win();

      if (do_clear) begin
        send_req(make_req(OP_CLEAR, SmpW'($urandom), SmpW'($urandom), SmpW'($urandom)),
                 1'b0, '0);
        rand_items++;
      end

      if (all_min) n_q = w_eff + 3;
      else n_q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, w_eff + 3) : w_eff;
      for (k = 0; k < n_q; k++) begin
        send_req(make_req(OP_QUERY, all_min ? 16'h8000 : rand_sample(sh), SmpW'($urandom),
                          SmpW'($urandom)), 1'b0, '0);
        rand_items++;
      end

      n_d = w_eff + ((w_eff > 64) ? $urandom_range(2, 6) : $urandom_range(4, 40));
      for (k = 0; k < n_d; k++) begin
        pick = all_min ? 63 : $urandom_range(0, 63);
        case (pick)
          0, 1:    op = OpUnused;
          2, 3:    op = OP_QUERY;
          4:       op = OP_CLEAR;
          default: op = OP_DATA;
        endcase
        r = make_req(op, all_min ? 16'h8000 : rand_sample(sh), rand_sample(sh), rand_dev());
        send_req(r, 1'b0, '0);
        if (op != OpUnused) rand_items++;
      end
    end

    // short window after a clear, then a few data requests with idling on both sides
    wait_drained();
    cfg_write(CFG_WIN_LEN, 16'd2);
    cfg_write(CFG_QDEV, CfgW'($urandom));
    cfg_we <= 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_req(make_req(OP_CLEAR, '0, '0, '0), 1'b0, '0);
    send_req(make_req(OpUnused, SmpW'($urandom), SmpW'($urandom), SmpW'($urandom)), 1'b0, '0);
    send_req(make_req(OP_CLEAR, SmpW'($urandom), SmpW'($urandom), SmpW'($urandom)), 1'b0, '0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (k = 0; k < 6; k++)
      send_req(make_req(OP_DATA, SmpW'($urandom), SmpW'($urandom), rand_dev()), 1'b0, '0);

    wait_drained();
    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
